// File: hw/rtl/b64e_pkg.sv
// shared types, character codes and sextet mapping for the base64 stream encoder
package b64e_pkg;

	// one input beat: a raw byte and its end-of-message flag
	typedef struct packed {
		logic [7:0] in_byte;
		logic       final_byte;
	} in_beat_t;

	// one result beat: an ascii character and its end-of-message flag
	typedef struct packed {
		logic [6:0] out_char;
		logic       last_char;
	} out_beat_t;

	// pad codes: how many trailing '=' a group carries
	localparam logic [1:0] PAD_NONE = 2'd0;
	localparam logic [1:0] PAD_ONE  = 2'd1;
	localparam logic [1:0] PAD_TWO  = 2'd2;

	// character positions inside a group
	localparam logic [1:0] POS_0 = 2'd0;
	localparam logic [1:0] POS_1 = 2'd1;
	localparam logic [1:0] POS_2 = 2'd2;
	localparam logic [1:0] POS_3 = 2'd3;

	// a complete group handed from the packer to the serializer
	typedef struct packed {
		logic [23:0] bits;
		logic [1:0]  pad;
		logic        fin;
	} group_t;

	localparam logic [6:0] CH_UPPER = 7'h41;
	localparam logic [6:0] CH_LOWER = 7'h61;
	localparam logic [6:0] CH_DIGIT = 7'h30;
	localparam logic [6:0] CH_PLUS  = 7'h2B;
	localparam logic [6:0] CH_SLASH = 7'h2F;
	localparam logic [6:0] CH_PAD   = 7'h3D;

	localparam logic [5:0] SEXTET_LOWER = 6'd26;
	localparam logic [5:0] SEXTET_DIGIT = 6'd52;
	localparam logic [5:0] SEXTET_PLUS  = 6'd62;

	// standard alphabet lookup for one 6-bit value
	function automatic logic [6:0] sextet_char(input logic [5:0] v);
		logic [6:0] ch;
		if (v < SEXTET_LOWER) begin
			ch = CH_UPPER + {1'b0, v};
		end else if (v < SEXTET_DIGIT) begin
			ch = CH_LOWER + {1'b0, 6'(v - SEXTET_LOWER)};
		end else if (v < SEXTET_PLUS) begin
			ch = CH_DIGIT + {1'b0, 6'(v - SEXTET_DIGIT)};
		end else if (v == SEXTET_PLUS) begin
			ch = CH_PLUS;
		end else begin
			ch = CH_SLASH;
		end
		return ch;
	endfunction

endpackage

// File: hw/rtl/b64e_front.sv
// byte packer: collects bytes into 24-bit groups and classifies the padding
module b64e_front import b64e_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  in_beat_t data,
	output logic     enq,
	output group_t   grp
);

	logic [15:0] pend_bytes_q;
	logic [1:0]  pend_cnt_q;
	logic        two_pend;

	assign two_pend = pend_cnt_q[1];

	// a group closes on the third byte or on a final byte
	assign enq = accept && (two_pend || data.final_byte);

	always_comb begin
		grp.fin = data.final_byte;
		if (two_pend) begin
			grp.bits = {pend_bytes_q, data.in_byte};
			grp.pad  = PAD_NONE;
		end else if (pend_cnt_q == 2'd1) begin
			grp.bits = {pend_bytes_q[7:0], data.in_byte, 8'h00};
			grp.pad  = PAD_ONE;
		end else begin
			grp.bits = {data.in_byte, 16'h0000};
			grp.pad  = PAD_TWO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bytes_q <= 16'h0000;
			pend_cnt_q   <= 2'd0;
		end else if (accept) begin
			if (enq) begin
				pend_bytes_q <= 16'h0000;
				pend_cnt_q   <= 2'd0;
			end else begin
				pend_bytes_q <= {pend_bytes_q[7:0], data.in_byte};
				pend_cnt_q   <= 2'(pend_cnt_q + 2'd1);
			end
		end
	end

	// count three is never reached
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		pend_cnt_q != 2'd3) else $error("pending count reached three");

endmodule

// File: hw/rtl/b64e_gq.sv
// small group queue between packer and serializer
module b64e_gq import b64e_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   enq,
	input  group_t enq_grp,
	input  logic   deq,
	output group_t head,
	output logic   full,
	output logic   empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	group_t          entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_enq;
	logic            do_deq;

	assign full   = (cnt_q == CW'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign do_enq = enq && !full;
	assign do_deq = deq && !empty;
	assign head   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_enq) begin
			entry_q[wr_ptr_q] <= enq_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_enq) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_q + 1'b1);
			end
			if (do_deq) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_q + 1'b1);
			end
			if (do_enq && !do_deq) begin
				cnt_q <= CW'(cnt_q + 1'b1);
			end else if (do_deq && !do_enq) begin
				cnt_q <= CW'(cnt_q - 1'b1);
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH)) else $error("group queue count overflow");

	a_ptr_sync: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> (wr_ptr_q == rd_ptr_q)) else $error("empty queue with pointers apart");

endmodule

// File: hw/rtl/b64e_back.sv
// serializer: head group to the result register, one character a cycle while free
module b64e_back import b64e_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  group_t    head,
	input  logic      grp_empty,
	output logic      deq,
	input  logic      pop,
	output logic      empty,
	output out_beat_t result
);

	logic [1:0] pos_q;
	logic [1:0] out_pos_q;
	logic       out_vld_q;
	out_beat_t  out_q;
	logic       load;
	logic       is_pad;
	logic [5:0] sextet;
	out_beat_t  nxt;

	assign load   = (!out_vld_q || pop) && !grp_empty;
	assign deq    = load && (pos_q == POS_3);
	assign empty  = !out_vld_q;
	assign result = out_q;

	always_comb begin
		unique case (pos_q)
			POS_0:   sextet = head.bits[23:18];
			POS_1:   sextet = head.bits[17:12];
			POS_2:   sextet = head.bits[11:6];
			default: sextet = head.bits[5:0];
		endcase
		is_pad = ((pos_q == POS_3) && (head.pad != PAD_NONE)) ||
			((pos_q == POS_2) && (head.pad == PAD_TWO));
		nxt.out_char  = is_pad ? CH_PAD : sextet_char(sextet);
		nxt.last_char = (pos_q == POS_3) && head.fin;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q     <= nxt;
			out_pos_q <= pos_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= POS_0;
			out_vld_q <= 1'b0;
		end else begin
			if (load) begin
				pos_q     <= 2'(pos_q + 2'd1);
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_q.last_char) |-> (out_pos_q == POS_3))
		else $error("last flag away from fourth character");

	a_pad_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && (out_q.out_char == CH_PAD)) |-> (out_pos_q == POS_2 || out_pos_q == POS_3))
		else $error("pad in first half of a group");

	a_refill: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_vld_q && !grp_empty) |=> out_vld_q)
		else $error("result register idle with a group waiting");

endmodule

// File: hw/rtl/base64_stream_encoder.sv
// top level of the streaming base64 encoder: packer, group queue, serializer
// a group-closing byte is queued, then its first character loads the result register
// throughput: one character a cycle from the result register while pop is high and
//   a group waits, four per group; bursts of up to GQ_DEPTH groups are absorbed
// full follows the group queue; bytes that only fill the packer still need a free slot
// reset: arst_n clears pending bytes, queue pointers and the result valid flag at once
module base64_stream_encoder import b64e_pkg::*; #(
	parameter int GQ_DEPTH = 4  // group queue entries, two or more
) (
	input  logic      clk,
	input  logic      arst_n,
	// byte side
	input  logic      push,
	output logic      full,
	input  in_beat_t  data,
	// character side
	output logic      empty,
	input  logic      pop,
	output out_beat_t result
);

	logic   accept;
	logic   enq;
	group_t enq_grp;
	group_t head;
	logic   grp_empty;
	logic   deq;

	// a byte beat is taken whenever the queue has room
	assign accept = push && !full;

	// front: packs bytes, closes a group on the third or the final byte
	b64e_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.data   (data),
		.enq    (enq),
		.grp    (enq_grp)
	);

	// decoupling queue of finished groups
	b64e_gq #(
		.DEPTH (GQ_DEPTH)
	) u_gq (
		.clk     (clk),
		.arst_n  (arst_n),
		.enq     (enq),
		.enq_grp (enq_grp),
		.deq     (deq),
		.head    (head),
		.full    (full),
		.empty   (grp_empty)
	);

	// back: four characters per group, padding and last flag applied
	b64e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.grp_empty (grp_empty),
		.deq       (deq),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

// File: tb/base64_stream_encoder_tb.sv
// self-checking testbench for the base64 stream encoder: byte beats in, checked characters out
module base64_stream_encoder_tb import b64e_pkg::*;;

	// run limits: hard stop on cycles, quiet time after the last expected character
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE_TICKS = 12;
	localparam int IDLE_PCT     = 32;
	localparam int MAX_REPORTS  = 100;

	// standard alphabet, index 0 in the top byte
	localparam logic [8*64-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	logic      clk = 1'b0;
	logic      arst_n;
	logic      push;
	logic      full;
	in_beat_t  data;
	logic      empty;
	logic      pop;
	out_beat_t result;

	base64_stream_encoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.data   (data),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always #5 clk = ~clk;

	// predictor state: bytes waiting for their group
	logic [15:0] held_bytes = '0;
	logic [1:0]  held_count = '0;

	// characters predicted but not yet seen on the result side
	out_beat_t expected_chars[$];

	// idling controls, hold-off request and run statistics
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int rx_hold_req  = 0;
	int rx_hold_left = 0;
	int err_count    = 0;
	int cycle_count  = 0;
	int bytes_sent   = 0;
	int msgs_sent    = 0;
	int chars_seen   = 0;
	int full_stalls  = 0;

	// one line per mismatch; printing is capped so a broken block cannot flood the log
	task automatic report_mismatch(input string what);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("mismatch @ cycle %0d: %s", cycle_count, what);
	endtask

	function automatic logic [6:0] sextet_to_ascii(input logic [5:0] v);
		return ALPHABET[8*(63 - v) +: 7];
	endfunction

	// advance the predictor by one accepted byte and queue the characters it yields
	task automatic predict_byte(input logic [7:0] b, input logic fin);
		logic [23:0] grp;
		int          n_sig;
		out_beat_t   ch;
		if (held_count >= 2) begin
			// third byte closes a full group, whatever the flag says
			grp   = {held_bytes, b};
			n_sig = 4;
		end else if (fin) begin
			if (held_count == 1) begin
				grp   = {held_bytes[7:0], b, 8'h00};
				n_sig = 3;
			end else begin
				grp   = {b, 16'h0000};
				n_sig = 2;
			end
		end else begin
			// plain byte: just held, nothing comes out
			held_bytes = {held_bytes[7:0], b};
			held_count = held_count + 2'd1;
			return;
		end
		for (int k = 0; k < 4; k++) begin
			ch.out_char  = (k < n_sig) ? sextet_to_ascii(grp[23 - 6*k -: 6]) : CH_PAD;
			ch.last_char = (k == 3) ? fin : 1'b0;
			expected_chars.push_back(ch);
		end
		held_bytes = '0;
		held_count = '0;
	endtask

	// offer one byte beat, idling first at random, and hold it until the block takes it
	task automatic send_byte(input logic [7:0] b, input logic fin);
		while (tx_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		data <= '{in_byte: b, final_byte: fin};
		// full is read before the edge updates it, so this is the accept condition
		do @(posedge clk); while (full);
		predict_byte(b, fin);
		bytes_sent++;
		if (fin)
			msgs_sent++;
	endtask

	// byte values lean toward the all-zero and all-one extremes
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// one message of n bytes, the flag on the last one only
	task automatic send_message(input int n);
		for (int i = 0; i < n; i++)
			send_byte(pick_byte(), i == n - 1);
	endtask

	// stop offering, wait for every expected character, then let stray output show up
	task automatic wait_drained();
		push <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	// result side: check each accepted character, then choose pop for the next edge
	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && pop && !empty) begin
			chars_seen++;
			if (expected_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
					result.out_char, result.last_char));
			end else begin
				want = expected_chars.pop_front();
				if (result.out_char !== want.out_char)
					report_mismatch($sformatf("out_char 0x%02h, want 0x%02h ('%c')",
						result.out_char, want.out_char, want.out_char));
				if (result.last_char !== want.last_char)
					report_mismatch($sformatf("last_char %0b, want %0b on '%c'",
						result.last_char, want.last_char, want.out_char));
			end
		end
		if (arst_n && push && full)
			full_stalls++;
		// a hold-off request is picked up here and counted down cycle by cycle
		if (rx_hold_req != 0) begin
			rx_hold_left = rx_hold_req;
			rx_hold_req  = 0;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= !(rx_idle_on && $urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d chars outstanding",
				cycle_count, expected_chars.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// hand-picked groups: pad forms, full groups, alphabet range edges
	task automatic test_directed();
		send_byte(8'h00, 1'b1);                          // "AA=="
		send_byte(8'hFF, 1'b1);                          // "/w=="
		send_byte(8'h4D, 1'b0); send_byte(8'h61, 1'b1);  // "TWE="
		send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b1);  // "//8="
		send_byte(8'h4D, 1'b0); send_byte(8'h61, 1'b0);
		send_byte(8'h6E, 1'b1);                          // "TWFu", last on the fourth
		// unflagged full group, then a flagged one in the same message
		send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b1);
		// "++++" then a flagged byte right at a fresh group start
		send_byte(8'hFB, 1'b0); send_byte(8'hEF, 1'b0); send_byte(8'hBE, 1'b0);
		send_byte(8'h69, 1'b1);
		// "ABCD", then "Zaz0" across the letter and digit edges, then "9+/A"
		send_byte(8'h00, 1'b0); send_byte(8'h10, 1'b0); send_byte(8'h83, 1'b0);
		send_byte(8'h65, 1'b0); send_byte(8'hAC, 1'b0); send_byte(8'hF4, 1'b0);
		send_byte(8'hF7, 1'b0); send_byte(8'hEF, 1'b0); send_byte(8'hC0, 1'b1);
		wait_drained();
	endtask

	// well-formed messages of random length and content, both sides idling
	task automatic test_random_messages();
		int sent;
		sent = 0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		while (sent < 260) begin
			int n;
			n = $urandom_range(1, 12);
			send_message(n);
			sent += n;
		end
		wait_drained();
	endtask

	// receiver stalls for a long stretch while bytes keep coming, so full must rise
	task automatic test_backpressure();
		tx_idle_on  = 1'b0;
		rx_hold_req = 200;
		for (int m = 0; m < 8; m++)
			send_message(6);
		tx_idle_on = 1'b1;
		// sender now pauses until every character is out
		wait_drained();
	endtask

	// a long run with no idling on either side
	task automatic test_steady_stream();
		int sent;
		sent = 0;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		while (sent < 90) begin
			int n;
			n = $urandom_range(1, 9);
			send_message(n);
			sent += n;
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		wait_drained();
	endtask

	// flags dropped at random points, including on third bytes of groups
	task automatic test_random_flags();
		for (int i = 0; i < 40; i++)
			send_byte(pick_byte(), $urandom_range(0, 99) < 30);
		// close whatever group is still open
		send_byte(pick_byte(), 1'b1);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		push   = 1'b0;
		pop    = 1'b0;
		data   = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_messages();
		test_backpressure();
		test_steady_stream();
		test_random_flags();

		if (expected_chars.size() != 0)
			report_mismatch($sformatf("%0d expected chars never came", expected_chars.size()));
		$display("covered %0d bytes in %0d messages, %0d characters checked",
			bytes_sent, msgs_sent, chars_seen);
		$display("input held off by full for %0d cycles, %0d mismatches",
			full_stalls, err_count);
		if (err_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/b64e_pkg.sv
hw/rtl/b64e_front.sv
hw/rtl/b64e_gq.sv
hw/rtl/b64e_back.sv
hw/rtl/base64_stream_encoder.sv
tb/base64_stream_encoder_tb.sv
